// ===== rtl/core/bpc_pkg.sv =====
// bpc_pkg: shared constants, item types and helpers for the block permutation cipher
// used by every module under rtl/core
package bpc_pkg;

	localparam int MAX_BLOCK = 8;
	localparam int IDX_W     = $clog2(MAX_BLOCK);
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0]       PAD_BYTE        = 8'h20;
	localparam logic [CNT_W-1:0] BLOCK_SIZE_RST  = 4'd4;
	localparam logic [31:0]      PERM_MAP_RST    = 32'h0000_1423;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE = 2'd0,
		REG_PERM_MAP   = 2'd1,
		REG_MODE       = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic             load;
		logic [CNT_W-1:0] held;
	} grp_load_t;

	// block size clamped to 1..MAX_BLOCK
	function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] k;
		k = v;
		if (v == '0) begin
			k = CNT_W'(1);
		end else if (v > CNT_W'(MAX_BLOCK)) begin
			k = CNT_W'(MAX_BLOCK);
		end
		return k;
	endfunction

endpackage

// ===== rtl/core/bpc_collect.sv =====
// bpc_collect: group buffer and fill count, detects the byte that closes a group
// depends on bpc_pkg
module bpc_collect (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  bpc_pkg::in_item_t                      in_item,
	input  logic [bpc_pkg::CNT_W-1:0]              ksize,
	input  logic                                   mode,
	input  logic                                   emit_free,
	output bpc_pkg::grp_load_t                     grp_load,
	output logic [bpc_pkg::MAX_BLOCK-1:0][7:0]     group
);
	import bpc_pkg::*;

	logic [CNT_W-1:0]           fill_q;
	logic [MAX_BLOCK-1:0][7:0]  gbuf_q;
	logic [CNT_W-1:0]           fill_next;
	logic [IDX_W-1:0]           wr_idx;
	logic                       full;
	logic                       close;
	logic                       emit;
	logic                       accept;

	assign wr_idx    = fill_q[IDX_W-1:0];
	assign fill_next = fill_q + CNT_W'(1);
	assign full      = fill_next >= ksize;
	assign close     = full || in_item.in_final;
	assign emit      = full || (in_item.in_final && !mode);
	assign in_stall  = in_valid && emit && !emit_free;
	assign accept    = in_valid && !in_stall;

	assign grp_load.load = accept && emit;
	assign grp_load.held = full ? ksize : fill_next;

	// group as it stands once the current byte is in
	always_comb begin
		for (int i = 0; i < MAX_BLOCK; i++) begin
			group[i] = (IDX_W'(i) == wr_idx) ? in_item.in_byte : gbuf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= close ? '0 : fill_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gbuf_q[wr_idx] <= in_item.in_byte;
		end
	end

endmodule

// ===== rtl/core/bpc_emit.sv =====
// bpc_emit: holds one closed group and sends its permuted bytes through the output register
// depends on bpc_pkg
module bpc_emit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bpc_pkg::grp_load_t                     grp_load,
	input  logic [bpc_pkg::MAX_BLOCK-1:0][7:0]     group,
	input  logic [bpc_pkg::CNT_W-1:0]              ksize,
	input  logic                                   mode,
	input  logic [31:0]                            perm_map,
	output logic                                   emit_free,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output bpc_pkg::out_item_t                     out_item
);
	import bpc_pkg::*;

	logic                       busy_q;
	logic [MAX_BLOCK-1:0][7:0]  ebuf_q;
	logic [CNT_W-1:0]           held_q;
	logic [IDX_W-1:0]           pos_q;
	logic [IDX_W-1:0]           last_q;
	logic                       ovalid_q;
	out_item_t                  oitem_q;

	logic                       advance;
	logic                       last_pos;
	logic [3:0]                 src;
	logic [3:0]                 srcm1;
	logic [3:0]                 want;
	logic                       inv_found;
	logic [IDX_W-1:0]           inv_idx;
	logic [7:0]                 sel_byte;

	assign advance   = busy_q && (!ovalid_q || !out_stall);
	assign last_pos  = pos_q == last_q;
	assign emit_free = !busy_q || (advance && last_pos);

	assign src   = perm_map[{pos_q, 2'b00} +: 4];
	assign srcm1 = src - 4'd1;
	assign want  = {1'b0, pos_q} + 4'd1;

	// inverse lookup, lowest matching position wins
	always_comb begin
		inv_found = 1'b0;
		inv_idx   = '0;
		for (int i = MAX_BLOCK - 1; i >= 0; i--) begin
			if (IDX_W'(i) <= last_q && perm_map[i*4 +: 4] == want) begin
				inv_found = 1'b1;
				inv_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		sel_byte = PAD_BYTE;
		if (!mode) begin
			if (src != 4'd0 && srcm1 <= {1'b0, last_q} && srcm1 < held_q) begin
				sel_byte = ebuf_q[srcm1[IDX_W-1:0]];
			end
		end else if (inv_found && {1'b0, inv_idx} < held_q) begin
			sel_byte = ebuf_q[inv_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			pos_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			if (grp_load.load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (advance && last_pos) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				pos_q <= pos_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load.load) begin
			ebuf_q <= group;
			held_q <= grp_load.held;
			last_q <= IDX_W'(ksize - CNT_W'(1));
		end
		if (advance) begin
			oitem_q.out_byte <= sel_byte;
			oitem_q.out_last <= last_pos;
		end
	end

	assign out_valid = ovalid_q;
	assign out_item  = oitem_q;

endmodule

// ===== rtl/core/block_permutation_cipher_unit.sv =====
// block_permutation_cipher_unit: top level, config registers, collector and emitter
// depends on bpc_pkg, bpc_collect, bpc_emit
// the closing item loads its group into the emitter buffer; the first byte then passes through the output register
// throughput: one item in and one item out per cycle while neither side is stalled
// the closing item of a group waits only while the previous group still has bytes to send
// reset: arst_n clears fill count, emitter and output valid, config to size 4, perm 3,2,4,1, encrypt
module block_permutation_cipher_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bpc_pkg::in_item_t                 in_item,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bpc_pkg::out_item_t                out_item,
	input  logic                              cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]         cfg_data
);
	import bpc_pkg::*;

	logic [CNT_W-1:0]           block_size_q;
	logic [31:0]                perm_map_q;
	logic                       mode_q;
	logic [CNT_W-1:0]           ksize;
	logic                       emit_free;
	grp_load_t                  grp_load;
	logic [MAX_BLOCK-1:0][7:0]  group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RST;
			perm_map_q   <= PERM_MAP_RST;
			mode_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCK_SIZE: block_size_q <= cfg_data[CNT_W-1:0];
				REG_PERM_MAP:   perm_map_q   <= cfg_data[31:0];
				REG_MODE:       mode_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ksize = eff_size(block_size_q);

	bpc_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.ksize     (ksize),
		.mode      (mode_q),
		.emit_free (emit_free),
		.grp_load  (grp_load),
		.group     (group)
	);

	bpc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_load  (grp_load),
		.group     (group),
		.ksize     (ksize),
		.mode      (mode_q),
		.perm_map  (perm_map_q),
		.emit_free (emit_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/bpc_checker.sv =====
// bpc_checker: port-level checks on the block permutation cipher, bound to the top level
// depends on bpc_pkg and block_permutation_cipher_unit
module bpc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input bpc_pkg::out_item_t  out_item
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	// stall only raised against a waiting item
	a_stall_valid: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid)
		else $error("input stall without input valid");

	// bytes of one group leave back to back
	a_group_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_item.out_last |=> out_valid)
		else $error("gap inside an output group");

	// a fresh stall comes only on a closing byte while a group is still going out
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid) || out_valid || $past(in_valid && !in_stall))
		else $error("input stalled with no group in flight");

endmodule

bind block_permutation_cipher_unit bpc_checker u_bpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
